>>> design/indexed_shift_array_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed shift array unit
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_ARRAY_UNIT_ASSERT_SVH
`define INDEXED_SHIFT_ARRAY_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/isa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_pkg
// Types, operation codes and sizes shared by the indexed shift array unit.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned OP_W           = 2;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 5'd10;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Command transaction
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // Response transaction
  typedef struct packed {
    logic                     accepted;
    logic signed [WORD_W-1:0] removed_value;
    logic [COUNT_W-1:0]       entry_count;
  } rsp_t;

  // Broadcast from the controller to every cell; only accepted ops are set
  typedef struct packed {
    logic                     do_append;
    logic                     do_insert;
    logic                     do_delete;
    logic [POS_W-1:0]         pos;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

>>> design/isa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_cell
// One array slot: loads the new word, its left or right neighbor, or holds.
// ----------------------------------------------------------------------------
module isa_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                             clk,
  input  isa_pkg::cell_ctl_t               ctl,
  input  logic signed [isa_pkg::WORD_W-1:0] left,
  input  logic signed [isa_pkg::WORD_W-1:0] right,
  input  logic signed [isa_pkg::WORD_W-1:0] rmv_in,
  output logic signed [isa_pkg::WORD_W-1:0] rmv_out,
  output logic signed [isa_pkg::WORD_W-1:0] word
);
  import isa_pkg::*;

  logic signed [WORD_W-1:0] word_next;
  logic                     at_pos;
  logic                     at_count;
  logic                     above_pos;
  logic                     in_live;
  logic                     below_last;

  // Position of this slot against the broadcast index and count
  assign at_pos     = (IDX == int'(ctl.pos));
  assign at_count   = (IDX == int'(ctl.count));
  assign above_pos  = (IDX >  int'(ctl.pos));
  assign in_live    = (IDX <= int'(ctl.count));
  assign below_last = ((IDX + 1) < int'(ctl.count));

  // Shift select
  always_comb begin
    word_next = word;
    if (ctl.do_append && at_count) begin
      word_next = ctl.value;
    end else if (ctl.do_insert) begin
      if (at_pos) begin
        word_next = ctl.value;
      end else if (above_pos && in_live) begin
        word_next = left;
      end
    end else if (ctl.do_delete && (at_pos || above_pos) && below_last) begin
      word_next = right;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Removed word travels along the chain; only the slot at pos contributes
  assign rmv_out = rmv_in | ((ctl.do_delete && at_pos) ? word : '0);

endmodule

>>> design/indexed_shift_array_unit.sv
`timescale 1ns / 1ps
// The response is registered at the edge the command is taken.
// Throughput: one command per cycle; a stalled response stalls the command side.
// Every slot shifts in parallel in the same cycle, so insert and delete cost
// the same as append. Reset clears the count, the response valid and sets
// the capacity limit to 10; stored words are not cleared.
// ----------------------------------------------------------------------------
// indexed_shift_array_unit
// Bounded ordered array with append, insert at index and delete at index.
// ----------------------------------------------------------------------------
module indexed_shift_array_unit #(
  parameter int unsigned CAPACITY = isa_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  isa_pkg::cmd_t                 cmd,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output isa_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [isa_pkg::COUNT_W-1:0]   cfg_data
);
  import isa_pkg::*;

  logic [COUNT_W-1:0]       cap_limit;
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic                     take;
  logic                     room;
  logic                     ins_ok;
  logic                     del_ok;
  logic                     app_ok;
  cell_ctl_t                ctl;
  logic signed [WORD_W-1:0] words [CAPACITY];
  logic signed [WORD_W-1:0] rmv   [CAPACITY+1];

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cmd_stall = rsp_valid && rsp_stall;
  assign take      = cmd_valid && !cmd_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_limit <= cfg_data;
    end
  end

  // Operation checks
  assign room   = (count < cap_limit) && (32'(count) < 32'(CAPACITY));
  assign app_ok = (cmd.op == OP_APPEND) && room;
  assign ins_ok = (cmd.op == OP_INSERT) && room && (cmd.index <= count);
  assign del_ok = (cmd.op == OP_DELETE) && (cmd.index < count);

  always_comb begin
    count_next = count;
    if (app_ok || ins_ok) begin
      count_next = count + 1'b1;
    end else if (del_ok) begin
      count_next = count - 1'b1;
    end
  end

  // Broadcast to the cells
  assign ctl.do_append = take && app_ok;
  assign ctl.do_insert = take && ins_ok;
  assign ctl.do_delete = take && del_ok;
  assign ctl.pos       = cmd.index;
  assign ctl.count     = count;
  assign ctl.value     = cmd.value;

  // Chain of cells
  assign rmv[0] = '0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_word;
    logic signed [WORD_W-1:0] right_word;
    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end
    isa_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .left   (left_word),
      .right  (right_word),
      .rmv_in (rmv[i]),
      .rmv_out(rmv[i+1]),
      .word   (words[i])
    );
  end

  // Count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.accepted      <= app_ok || ins_ok || del_ok;
      rsp.removed_value <= rmv[CAPACITY];
      rsp.entry_count   <= count_next;
    end
  end

endmodule

>>> design/isa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_checker
// Port-level checks on the indexed shift array unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_shift_array_unit_assert.svh"

module isa_checker #(
  parameter int unsigned CAPACITY = isa_pkg::DEF_CAPACITY
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_stall,
  input isa_pkg::cmd_t               cmd,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input isa_pkg::rsp_t               rsp,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [isa_pkg::COUNT_W-1:0] cfg_data
);
  import isa_pkg::*;

  // A waiting response holds still
  `ISA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response changed while stalled")

  // Refused transactions carry no removed word
  `ISA_ASSERT_NOW(a_refused_zero, rsp_valid && !rsp.accepted, rsp.removed_value == '0, "refused transaction returned a word")

  // Count never exceeds the array size
  `ISA_ASSERT_NOW(a_count_bound, rsp_valid, 32'(rsp.entry_count) <= 32'(CAPACITY), "entry count above capacity")

  // Commands are only held back by a stalled response
  `ISA_ASSERT_NOW(a_stall_cause, cmd_stall, rsp_valid && rsp_stall, "command stalled without a stalled response")

endmodule

bind indexed_shift_array_unit isa_checker #(
  .CAPACITY(CAPACITY)
) u_isa_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd_valid),
  .cmd_stall(cmd_stall),
  .cmd      (cmd),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .cfg_data (cfg_data)
);
